// File: rtl/core/chgw_pkg.sv
package chgw_pkg;

    // Default sizing of the point store and the coordinate word
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;

endpackage

// File: rtl/core/chgw_point_if.sv
// Point stream: one input point per transaction
interface chgw_point_if #(
    parameter int COORD_BITS = chgw_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_point;

    modport source (
        output valid,
        output point_x,
        output point_y,
        output last_point,
        input  ready
    );

    modport sink (
        input  valid,
        input  point_x,
        input  point_y,
        input  last_point,
        output ready
    );
endinterface

// File: rtl/core/chgw_hull_if.sv
// Hull stream: one hull vertex per transaction
interface chgw_hull_if #(
    parameter int COORD_BITS = chgw_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] hull_x;
    logic signed [COORD_BITS-1:0] hull_y;
    logic                         last_vertex;
    logic                         overflowed;

    modport source (
        output valid,
        output hull_x,
        output hull_y,
        output last_vertex,
        output overflowed,
        input  ready
    );

    modport sink (
        input  valid,
        input  hull_x,
        input  hull_y,
        input  last_vertex,
        input  overflowed,
        output ready
    );
endinterface

// File: rtl/core/convex_hull_gift_wrap.sv
// Channel  Role    Payload
// -------  ------  ---------------------------------------------------
// points   sink    point_x, point_y (signed), last_point
// hull     source  hull_x, hull_y (signed), last_vertex, overflowed
//
// Loading takes one point per cycle; the leftmost point is tracked on the fly.
// Walk: each stored point but the current vertex is a candidate, taking one
// store read and two passes through the single shared multiplier. Emission
// reads each vertex back through the index list and waits out any hull stall;
// points is not ready from the last point until the final vertex transaction.
// Reset clears the control registers only; the point stores are not cleared.
module convex_hull_gift_wrap #(
    parameter int MAX_POINTS = chgw_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chgw_pkg::COORD_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    chgw_point_if.sink    points,
    chgw_hull_if.source   hull
);
    import chgw_pkg::*;

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int DW    = COORD_BITS + 1;
    localparam int PW    = 2 * DW;

    typedef enum logic [13:0] {
        ST_LOAD = 14'b00000000000001,
        ST_INIT = 14'b00000000000010,
        ST_QRD  = 14'b00000000000100,
        ST_QLD  = 14'b00000000001000,
        ST_KRD  = 14'b00000000010000,
        ST_DIFF = 14'b00000000100000,
        ST_MUL1 = 14'b00000001000000,
        ST_MUL2 = 14'b00000010000000,
        ST_CMP  = 14'b00000100000000,
        ST_STEP = 14'b00001000000000,
        ST_ERD1 = 14'b00010000000000,
        ST_ERD2 = 14'b00100000000000,
        ST_OLD  = 14'b01000000000000,
        ST_OUT  = 14'b10000000000000
    } state_t;

    // Control state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               drop_reg, drop_next;
    logic               guard_reg, guard_next;
    logic [CNT_W-1:0]   emitted_reg, emitted_next;
    logic [IDX_W-1:0]   start_reg, start_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [IDX_W-1:0]   q_reg, q_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [IDX_W-1:0]   e_reg, e_next;

    // Storage and datapath
    logic signed [COORD_BITS-1:0] store_x [MAX_POINTS];
    logic signed [COORD_BITS-1:0] store_y [MAX_POINTS];
    logic [IDX_W-1:0]             idx_mem [MAX_POINTS];
    logic signed [COORD_BITS-1:0] rd_x_reg, rd_y_reg;
    logic [IDX_W-1:0]             idx_rd_reg;
    logic signed [COORD_BITS-1:0] min_x_reg, min_y_reg;
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg;
    logic signed [COORD_BITS-1:0] qx_reg, qy_reg;
    logic signed [COORD_BITS-1:0] kx_reg, ky_reg;
    logic signed [DW-1:0]         dxi_reg, dyi_reg, dxq_reg, dyq_reg;
    logic signed [PW-1:0]         pa_reg, pb_reg;
    logic signed [COORD_BITS-1:0] hull_x_reg, hull_y_reg;
    logic                         last_vertex_reg, overflowed_reg;

    logic               in_fire, out_fire, store_en, take_min;
    logic               k_last, turn_pos, idx_wr_en, out_last;
    logic [IDX_W-1:0]   rd_addr, idx_wr_addr, idx_wr_data, succ_base, succ;
    logic [CNT_W-1:0]   succ_ext;
    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;

    // Handshakes
    assign points.ready = (state_reg == ST_LOAD);
    assign hull.valid   = (state_reg == ST_OUT);
    assign in_fire      = points.valid && points.ready;
    assign out_fire     = hull.valid && hull.ready;

    assign hull.hull_x      = hull_x_reg;
    assign hull.hull_y      = hull_y_reg;
    assign hull.last_vertex = last_vertex_reg;
    assign hull.overflowed  = overflowed_reg;

    // Point store write and leftmost tracking
    assign store_en = in_fire && (count_reg < CNT_W'(MAX_POINTS));
    assign take_min = store_en && ((count_reg == '0) || (points.point_x < min_x_reg));

    // Cyclic successor of the start or current candidate index
    assign succ_base = (state_reg == ST_INIT) ? start_reg : q_reg;
    assign succ_ext  = CNT_W'(succ_base) + CNT_W'(1);
    assign succ      = (succ_ext == count_reg) ? '0 : succ_ext[IDX_W-1:0];

    assign k_last   = (CNT_W'(k_reg) + CNT_W'(1)) == count_reg;
    assign out_last = (CNT_W'(e_reg) + CNT_W'(1)) == emitted_reg;

    // Shared multiplier: dxi*dyq on the first pass, dyi*dxq on the second
    assign mul_a = (state_reg == ST_MUL1) ? dxi_reg : dyi_reg;
    assign mul_b = (state_reg == ST_MUL1) ? dyq_reg : dxq_reg;
    assign mul_p = mul_a * mul_b;

    // Cross product strictly positive
    assign turn_pos = pa_reg > pb_reg;

    // Store read address
    always_comb
    begin
        unique case (state_reg)
            ST_QRD:  rd_addr = q_reg;
            ST_ERD2: rd_addr = idx_rd_reg;
            default: rd_addr = k_reg;
        endcase
    end

    // Hull index list write
    assign idx_wr_en   = (state_reg == ST_INIT) ||
                         ((state_reg == ST_STEP) && (q_reg != start_reg) &&
                          (emitted_reg != CNT_W'(MAX_POINTS)));
    assign idx_wr_addr = (state_reg == ST_INIT) ? '0 : emitted_reg[IDX_W-1:0];
    assign idx_wr_data = (state_reg == ST_INIT) ? start_reg : q_reg;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        drop_next    = drop_reg;
        guard_next   = guard_reg;
        emitted_next = emitted_reg;
        start_next   = start_reg;
        cur_next     = cur_reg;
        q_next       = q_reg;
        k_next       = k_reg;
        e_next       = e_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (store_en)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (take_min)
                    begin
                        start_next = count_reg[IDX_W-1:0];
                    end
                    if (points.last_point)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                cur_next     = start_reg;
                q_next       = succ;
                emitted_next = CNT_W'(1);
                guard_next   = 1'b0;
                state_next   = ST_QRD;
            end
            ST_QRD:
            begin
                k_next     = '0;
                state_next = ST_QLD;
            end
            ST_QLD:
            begin
                state_next = ST_KRD;
            end
            ST_KRD:
            begin
                if (k_reg == cur_reg)
                begin
                    if (k_last)
                    begin
                        state_next = ST_STEP;
                    end
                    else
                    begin
                        k_next = k_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (turn_pos)
                begin
                    q_next = k_reg;
                end
                if (k_last)
                begin
                    state_next = ST_STEP;
                end
                else
                begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = ST_KRD;
                end
            end
            ST_STEP:
            begin
                e_next = '0;
                if (q_reg == start_reg)
                begin
                    state_next = ST_ERD1;
                end
                else if (emitted_reg == CNT_W'(MAX_POINTS))
                begin
                    guard_next = 1'b1;
                    state_next = ST_ERD1;
                end
                else
                begin
                    emitted_next = emitted_reg + CNT_W'(1);
                    cur_next     = q_reg;
                    q_next       = succ;
                    state_next   = ST_QRD;
                end
            end
            ST_ERD1:
            begin
                state_next = ST_ERD2;
            end
            ST_ERD2:
            begin
                state_next = ST_OLD;
            end
            ST_OLD:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    if (out_last)
                    begin
                        count_next = '0;
                        drop_next  = 1'b0;
                        guard_next = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        e_next     = e_reg + IDX_W'(1);
                        state_next = ST_ERD1;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            drop_reg    <= 1'b0;
            guard_reg   <= 1'b0;
            emitted_reg <= '0;
            start_reg   <= '0;
            cur_reg     <= '0;
            q_reg       <= '0;
            k_reg       <= '0;
            e_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            drop_reg    <= drop_next;
            guard_reg   <= guard_next;
            emitted_reg <= emitted_next;
            start_reg   <= start_next;
            cur_reg     <= cur_next;
            q_reg       <= q_next;
            k_reg       <= k_next;
            e_reg       <= e_next;
        end
    end

    // Point store and hull index list
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            store_x[count_reg[IDX_W-1:0]] <= points.point_x;
            store_y[count_reg[IDX_W-1:0]] <= points.point_y;
        end
        rd_x_reg <= store_x[rd_addr];
        rd_y_reg <= store_y[rd_addr];

        if (idx_wr_en)
        begin
            idx_mem[idx_wr_addr] <= idx_wr_data;
        end
        idx_rd_reg <= idx_mem[e_reg];
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (take_min)
        begin
            min_x_reg <= points.point_x;
            min_y_reg <= points.point_y;
        end

        if (state_reg == ST_INIT)
        begin
            cx_reg <= min_x_reg;
            cy_reg <= min_y_reg;
        end
        else if (state_reg == ST_STEP)
        begin
            cx_reg <= qx_reg;
            cy_reg <= qy_reg;
        end

        if (state_reg == ST_QLD)
        begin
            qx_reg <= rd_x_reg;
            qy_reg <= rd_y_reg;
        end
        else if ((state_reg == ST_CMP) && turn_pos)
        begin
            qx_reg <= kx_reg;
            qy_reg <= ky_reg;
        end

        // Differences against the current vertex
        if (state_reg == ST_DIFF)
        begin
            kx_reg  <= rd_x_reg;
            ky_reg  <= rd_y_reg;
            dxi_reg <= DW'(rd_x_reg) - DW'(cx_reg);
            dyi_reg <= DW'(rd_y_reg) - DW'(cy_reg);
            dxq_reg <= DW'(qx_reg) - DW'(cx_reg);
            dyq_reg <= DW'(qy_reg) - DW'(cy_reg);
        end

        if (state_reg == ST_MUL1)
        begin
            pa_reg <= mul_p;
        end
        if (state_reg == ST_MUL2)
        begin
            pb_reg <= mul_p;
        end

        // Output payload
        if (state_reg == ST_OLD)
        begin
            hull_x_reg      <= rd_x_reg;
            hull_y_reg      <= rd_y_reg;
            last_vertex_reg <= out_last;
            overflowed_reg  <= drop_reg || guard_reg;
        end
    end

    // Checks
    a_load_excl_emit: assert property (@(posedge clk) disable iff (!rst_n)
        points.ready |-> !hull.valid)
        else $error("point load overlaps hull emission");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg |-> (count_reg == CNT_W'(MAX_POINTS)))
        else $error("drop flag set with store not full");

    a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && hull.last_vertex) |=>
            (points.ready && (count_reg == '0) && !drop_reg))
        else $error("set not cleared after final vertex");

endmodule

// File: verif/tb_convex_hull_gift_wrap.sv
module tb_convex_hull_gift_wrap;
    import chgw_pkg::*;

    localparam int     MaxPts      = MAX_POINTS_DEF;
    localparam int     CoordBits   = COORD_BITS_DEF;
    localparam int     ItemTarget  = 320;
    localparam int     DirCount    = 21;
    localparam int     TypedCount  = 5;
    localparam int     MaxReports  = 10;
    localparam int     DrainCycles = 200;
    localparam longint RunLimit    = 64'd40_000_000;

    typedef logic signed [CoordBits-1:0] coord_t;

    typedef struct packed {
        coord_t     px;
        coord_t     py;
        logic       last;
        logic [2:0] typed_cnt;   // hand-written hull vertices for this row, 0 = use predictor
    } point_row_t;

    typedef struct packed {
        coord_t px;
        coord_t py;
    } point_t;

    typedef struct packed {
        coord_t hx;
        coord_t hy;
        logic   last_vertex;
        logic   overflowed;
    } hull_vertex_t;

    typedef enum int {
        ShapeWide,   // full coordinate range, extremes mixed in
        ShapeGrid,   // tiny grid: duplicates and collinear runs
        ShapeMid,    // moderate spread
        ShapeArc     // convex arc, every point on the hull
    } set_shape_t;

    logic clk = 1'b0;
    logic rst_n;

    chgw_point_if #(.COORD_BITS(CoordBits)) point_ch ();
    chgw_hull_if  #(.COORD_BITS(CoordBits)) hull_ch ();

    convex_hull_gift_wrap #(
        .MAX_POINTS (MaxPts),
        .COORD_BITS (CoordBits)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .points (point_ch),
        .hull   (hull_ch)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Directed stimulus: extremes, tiny sets, interior/collinear/duplicate points,
    // a walk that never returns to its start, alternating bit patterns
    point_row_t dir_rows [DirCount] = '{
        '{16'sd5,     -16'sd7,    1'b1, 3'd1},  // lone point right after reset
        '{16'sh8000,  16'sh8000,  1'b0, 3'd0},  // two-point set, corners
        '{16'sh7FFF,  16'sh7FFF,  1'b1, 3'd2},
        '{16'sh7FFF,  16'sh8000,  1'b0, 3'd0},  // leftmost point comes second
        '{16'sh8000,  16'sh7FFF,  1'b1, 3'd2},
        '{16'sd0,     16'sd0,     1'b0, 3'd0},  // triangle, interior and edge points
        '{16'sd100,   16'sd0,     1'b0, 3'd0},
        '{16'sd50,    16'sd20,    1'b0, 3'd0},
        '{16'sd50,    16'sd0,     1'b0, 3'd0},
        '{16'sd50,    16'sd100,   1'b1, 3'd0},
        '{16'sd7,     16'sd7,     1'b0, 3'd0},  // all points identical
        '{16'sd7,     16'sd7,     1'b0, 3'd0},
        '{16'sd7,     16'sd7,     1'b1, 3'd0},
        '{16'sd0,     16'sd0,     1'b0, 3'd0},  // tied leftmost column: walk loops, guard trips
        '{16'sd0,     16'sd10,    1'b0, 3'd0},
        '{16'sd0,     -16'sd10,   1'b0, 3'd0},
        '{16'sd10,    16'sd0,     1'b1, 3'd0},
        '{-16'sd1,    -16'sd1,    1'b0, 3'd0},  // alternating bit patterns
        '{16'sh5555,  16'shAAAA,  1'b0, 3'd0},
        '{16'shAAAA,  16'sh5555,  1'b0, 3'd0},
        '{16'sh7FFF,  16'sd0,     1'b1, 3'd0}
    };

    hull_vertex_t typed_hull [TypedCount] = '{
        '{16'sd5,     -16'sd7,    1'b1, 1'b0},
        '{16'sh8000,  16'sh8000,  1'b0, 1'b0},
        '{16'sh7FFF,  16'sh7FFF,  1'b1, 1'b0},
        '{16'sh8000,  16'sh7FFF,  1'b0, 1'b0},
        '{16'sh7FFF,  16'sh8000,  1'b1, 1'b0}
    };

    // Predictor state
    coord_t       pts_x [MaxPts];
    coord_t       pts_y [MaxPts];
    int           stored;
    bit           dropped;
    hull_vertex_t walk_verts [$];

    // Scoreboard and run control
    hull_vertex_t hull_expected [$];
    int           errors;
    int           items_sent;
    int           src_idle_pct;
    int           sink_idle_pct;

    // True when point i lies strictly on the outer side of cur->cand
    function automatic bit swings_out(int cur, int i, int cand);
        longint dxi, dyi, dxq, dyq;
        dxi = longint'(pts_x[i]) - longint'(pts_x[cur]);
        dyi = longint'(pts_y[i]) - longint'(pts_y[cur]);
        dxq = longint'(pts_x[cand]) - longint'(pts_x[cur]);
        dyq = longint'(pts_y[cand]) - longint'(pts_y[cur]);
        return (dxi * dyq - dyi * dxq) > 0;
    endfunction

    // Queue one vertex behind the pending expectations
    function automatic void expect_vertex(hull_vertex_t v);
        hull_expected.insert(hull_expected.size(), v);
    endfunction

    // Store one point; on the closing point, walk the hull into walk_verts
    function automatic void wrap_point(coord_t x, coord_t y, logic last);
        int           n;
        int           start;
        int           cur;
        int           cand;
        int           k;
        bit           guard;
        int           order [$];
        hull_vertex_t vert;
        walk_verts.delete();
        if (stored < MaxPts)
        begin
            pts_x[stored] = x;
            pts_y[stored] = y;
            stored++;
        end
        else
        begin
            dropped = 1'b1;
        end
        if (!last)
            return;

        n = stored;
        start = 0;
        for (k = 1; k < n; k++)
            if (pts_x[k] < pts_x[start])
                start = k;

        order.insert(order.size(), start);
        cur = start;
        guard = 1'b0;
        forever
        begin
            cand = (cur + 1) % n;
            for (k = 0; k < n; k++)
                if (k != cur && swings_out(cur, k, cand))
                    cand = k;
            cur = cand;
            if (cand == start)
                break;
            if (order.size() >= MaxPts)
            begin
                guard = 1'b1;
                break;
            end
            order.insert(order.size(), cand);
        end

        foreach (order[j])
        begin
            vert.hx          = pts_x[order[j]];
            vert.hy          = pts_y[order[j]];
            vert.last_vertex = (j == order.size() - 1);
            vert.overflowed  = dropped || guard;
            walk_verts.insert(walk_verts.size(), vert);
        end
        stored = 0;
        dropped = 1'b0;
    endfunction

    function automatic coord_t pick_coord(set_shape_t shape);
        case (shape)
            ShapeGrid: return coord_t'(int'($urandom_range(4)) - 2);
            ShapeMid:  return coord_t'(int'($urandom_range(2000)) - 1000);
            default:
            begin
                if ($urandom_range(7) == 0)
                begin
                    case ($urandom_range(3))
                        0:       return 16'sh8000;
                        1:       return 16'sh7FFF;
                        2:       return 16'sd0;
                        default: return -16'sd1;
                    endcase
                end
                return coord_t'($urandom);
            end
        endcase
    endfunction

    // One point transaction, with random idle cycles ahead of it
    task automatic send_point(input coord_t x, input coord_t y, input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            point_ch.valid <= 1'b0;
            @(posedge clk);
        end
        point_ch.valid      <= 1'b1;
        point_ch.point_x    <= x;
        point_ch.point_y    <= y;
        point_ch.last_point <= last;
        do @(posedge clk); while (!point_ch.ready);
        items_sent++;
        wrap_point(x, y, last);
    endtask

    // A complete random point set, closed by its last point
    task automatic send_random_set();
        point_t     pts [$];
        point_t     tmp;
        set_shape_t shape;
        int         n;
        int         roll;
        int         off;
        int         j;
        int         pick;
        bit         flip;
        roll = $urandom_range(99);
        if (roll < 4)
            n = MaxPts;
        else if (roll < 8)
            n = MaxPts + 1 + $urandom_range(3);   // overfills the store
        else if (roll < 35)
            n = 1 + $urandom_range(3);
        else
            n = $urandom_range(12, 5);
        shape = set_shape_t'($urandom_range(3));
        flip = $urandom_range(1);

        for (j = 0; j < n; j++)
        begin
            if (shape == ShapeArc)
            begin
                off = j - n / 2;
                tmp.px = coord_t'(off * 500);
                tmp.py = coord_t'(flip ? 30000 - off * off * 30 : off * off * 30 - 30000);
            end
            else
            begin
                tmp.px = pick_coord(shape);
                tmp.py = pick_coord(shape);
            end
            pts.insert(pts.size(), tmp);
        end

        // shuffle so the store order differs from walk order
        for (j = n - 1; j > 0; j--)
        begin
            pick = $urandom_range(j);
            tmp = pts[j];
            pts[j] = pts[pick];
            pts[pick] = tmp;
        end

        for (j = 0; j < n; j++)
        begin
            send_point(pts[j].px, pts[j].py, j == n - 1);
            foreach (walk_verts[v])
                expect_vertex(walk_verts[v]);
        end
    endtask

    // Compare one hull transaction against the oldest expectation
    task automatic take_vertex();
        hull_vertex_t want;
        if (hull_expected.size() == 0)
        begin
            errors++;
            if (errors <= MaxReports)
                $display("unexpected hull vertex (%0d,%0d) last=%0b ovf=%0b",
                         hull_ch.hull_x, hull_ch.hull_y,
                         hull_ch.last_vertex, hull_ch.overflowed);
            return;
        end
        want = hull_expected.pop_front();
        if (hull_ch.hull_x !== want.hx || hull_ch.hull_y !== want.hy ||
            hull_ch.last_vertex !== want.last_vertex ||
            hull_ch.overflowed !== want.overflowed)
        begin
            errors++;
            if (errors <= MaxReports)
                $display("hull mismatch: exp (%0d,%0d) %0b/%0b, got (%0d,%0d) %0b/%0b",
                         want.hx, want.hy, want.last_vertex, want.overflowed,
                         hull_ch.hull_x, hull_ch.hull_y,
                         hull_ch.last_vertex, hull_ch.overflowed);
        end
    endtask

    // Hull receiver: check at each edge, then pick ready for the next
    initial
    begin
        hull_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hull_ch.valid && hull_ch.ready)
                take_vertex();
            hull_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Run limit
    initial
    begin
        #(RunLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Main stimulus
    initial
    begin
        int k;
        int typed_idx;
        int phase;
        int phase_end;
        rst_n               <= 1'b0;
        point_ch.valid      <= 1'b0;
        point_ch.point_x    <= '0;
        point_ch.point_y    <= '0;
        point_ch.last_point <= 1'b0;
        stored        = 0;
        dropped       = 1'b0;
        errors        = 0;
        items_sent    = 0;
        src_idle_pct  = 23;
        sink_idle_pct = 55;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        typed_idx = 0;
        for (k = 0; k < DirCount; k++)
        begin
            send_point(dir_rows[k].px, dir_rows[k].py, dir_rows[k].last);
            if (dir_rows[k].typed_cnt != 0)
            begin
                repeat (int'(dir_rows[k].typed_cnt))
                begin
                    expect_vertex(typed_hull[typed_idx]);
                    typed_idx++;
                end
            end
            else
            begin
                foreach (walk_verts[v])
                    expect_vertex(walk_verts[v]);
            end
        end

        // random sets in three idle profiles
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 23;
                    sink_idle_pct = 55;
                end
                1:
                begin
                    src_idle_pct  = 55;
                    sink_idle_pct = 23;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            phase_end = DirCount + (phase + 1) * (ItemTarget - DirCount) / 3;
            // hold the sender off until every pending vertex has come back
            point_ch.valid <= 1'b0;
            do @(posedge clk); while (hull_expected.size() != 0);
            while (items_sent < phase_end)
                send_random_set();
        end

        // drain, then watch for stray vertices
        point_ch.valid <= 1'b0;
        do @(posedge clk); while (hull_expected.size() != 0);
        repeat (DrainCycles) @(posedge clk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
rtl/core/chgw_pkg.sv
rtl/core/chgw_point_if.sv
rtl/core/chgw_hull_if.sv
rtl/core/convex_hull_gift_wrap.sv
verif/tb_convex_hull_gift_wrap.sv
